@@ hw/rtl/mam_pkg.sv @@
// shared types and constants for the matrix add / multiply engine
`timescale 1ns / 1ps
package mam_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int ELEM_BITS_DEF = 16;

	localparam int CMD_W  = 2;
	localparam int IDX_W  = 3;
	localparam int ELEM_W = 16;
	localparam int VAL_W  = 36;
	localparam int DIM_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_START  = 2'd2
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 3'd4;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_MUL = 1'b1;

	// tag that travels with each pair of operands through the arithmetic unit
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic add_mode;
	} mac_ctl_t;

endpackage

@@ hw/rtl/mam_if.sv @@
// valid/ready channel interfaces for items, results and register writes
`timescale 1ns / 1ps
interface mam_in_if
	import mam_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [IDX_W-1:0]  row_index;
	logic [IDX_W-1:0]  col_index;
	logic [ELEM_W-1:0] element;

	modport source (output valid, cmd, row_index, col_index, element, input ready);
	modport sink   (input valid, cmd, row_index, col_index, element, output ready);
endinterface

interface mam_out_if
	import mam_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic signed [VAL_W-1:0] out_value;
	logic                    dim_error;
	logic                    last;

	modport source (output valid, out_row, out_col, out_value, dim_error, last,
		input ready);
	modport sink   (input valid, out_row, out_col, out_value, dim_error, last,
		output ready);
endinterface

interface mam_cfg_if
	import mam_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/mam_store.sv @@
// element memory with one write port and one registered read port
`timescale 1ns / 1ps
module mam_store
	import mam_pkg::*;
#(
	parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
	parameter int WIDTH = ELEM_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ hw/rtl/mam_mac.sv @@
// shared multiply / add unit with product register and accumulator
`timescale 1ns / 1ps
module mam_mac
	import mam_pkg::*;
#(
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic [ELEM_BITS-1:0]    a_raw,
	input  logic [ELEM_BITS-1:0]    b_raw,
	output logic signed [VAL_W-1:0] acc,
	output logic                    done
);
	logic signed [ELEM_BITS-1:0]   a_s;
	logic signed [ELEM_BITS-1:0]   b_s;
	logic signed [2*ELEM_BITS-1:0] prod;
	logic signed [VAL_W-1:0]       sum;
	mac_ctl_t                      ctl_s2;
	logic signed [VAL_W-1:0]       val_s2;
	logic signed [VAL_W-1:0]       acc_q;
	logic                          done_q;

	assign a_s  = signed'(a_raw);
	assign b_s  = signed'(b_raw);
	assign prod = a_s * b_s;
	assign sum  = VAL_W'(a_s) + VAL_W'(b_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			val_s2 <= ctl.add_mode ? sum : VAL_W'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s2.valid && ctl_s2.last;
			if (ctl_s2.valid) begin
				acc_q <= ctl_s2.first ? val_s2 : acc_q + val_s2;
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;
endmodule

@@ hw/rtl/mam_ctrl.sv @@
// sequencer: config registers, start handling, operand addressing, result register
`timescale 1ns / 1ps
module mam_ctrl
	import mam_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    start,
	output logic                    idle,
	output logic                    re,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_a,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_b,
	output mac_ctl_t                ctl,
	input  logic signed [VAL_W-1:0] acc,
	input  logic                    done,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [IDX_W-1:0]        out_row,
	output logic [IDX_W-1:0]        out_col,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    dim_error,
	output logic                    last
);
	localparam int IW = $clog2(MAX_DIM);
	localparam int AW = $clog2(MAX_DIM * MAX_DIM);
	localparam int CW = DIM_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ERR,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	state_t              state_q;
	logic [DIM_W-1:0]    rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic                op_mode_q;
	logic [DIM_W-1:0]    nr_q, nc_q, nk_q;
	logic                add_q;
	logic [IW-1:0]       i_q, j_q, k_q;
	logic                got_q;
	mac_ctl_t            ctl_s1;
	logic                out_valid_q;
	logic [IDX_W-1:0]    out_row_q, out_col_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                dim_error_q, last_q;

	logic dims_ok, fit_ok;
	logic last_k, last_i, last_j;
	logic out_free, emit, err_emit;
	logic [IW-1:0] ra_row, ra_col, rb_row, rb_col;

	function automatic logic dim_ok(input logic [DIM_W-1:0] d);
		return (d != '0) && (CW'(d) <= CW'(MAX_DIM));
	endfunction

	assign dims_ok = dim_ok(rows_a_q) && dim_ok(cols_a_q) && dim_ok(rows_b_q)
		&& dim_ok(cols_b_q);
	assign fit_ok = (op_mode_q == OP_ADD)
		? (rows_a_q == rows_b_q) && (cols_a_q == cols_b_q)
		: (cols_a_q == rows_b_q);

	assign last_k = add_q || (CW'(k_q) + CW'(1) == CW'(nk_q));
	assign last_i = (CW'(i_q) + CW'(1) == CW'(nr_q));
	assign last_j = (CW'(j_q) + CW'(1) == CW'(nc_q));

	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == ST_WAIT) && (got_q || done) && out_free;
	assign err_emit = (state_q == ST_ERR) && out_free;

	assign ra_row = i_q;
	assign ra_col = add_q ? j_q : k_q;
	assign rb_row = add_q ? i_q : k_q;
	assign rb_col = j_q;
	assign raddr_a = AW'(AW'(ra_row) * AW'(MAX_DIM) + AW'(ra_col));
	assign raddr_b = AW'(AW'(rb_row) * AW'(MAX_DIM) + AW'(rb_col));
	assign re      = (state_q == ST_ISSUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_a_q    <= DIM_W'(8);
			cols_a_q    <= DIM_W'(8);
			rows_b_q    <= DIM_W'(8);
			cols_b_q    <= DIM_W'(8);
			op_mode_q   <= OP_MUL;
			nr_q        <= '0;
			nc_q        <= '0;
			nk_q        <= '0;
			add_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			got_q       <= 1'b0;
			ctl_s1      <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_value_q <= '0;
			dim_error_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS_A:  rows_a_q  <= cfg_data;
					REG_COLS_A:  cols_a_q  <= cfg_data;
					REG_ROWS_B:  rows_b_q  <= cfg_data;
					REG_COLS_B:  cols_b_q  <= cfg_data;
					REG_OP_MODE: op_mode_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (err_emit || emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					ctl_s1 <= '0;
					if (start) begin
						nr_q  <= rows_a_q;
						nc_q  <= (op_mode_q == OP_ADD) ? cols_a_q : cols_b_q;
						nk_q  <= cols_a_q;
						add_q <= (op_mode_q == OP_ADD);
						i_q   <= '0;
						j_q   <= '0;
						k_q   <= '0;
						got_q <= 1'b0;
						state_q <= (dims_ok && fit_ok) ? ST_ISSUE : ST_ERR;
					end
				end
				ST_ERR: begin
					ctl_s1 <= '0;
					if (err_emit) begin
						out_row_q   <= '0;
						out_col_q   <= '0;
						out_value_q <= '0;
						dim_error_q <= 1'b1;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_ISSUE: begin
					ctl_s1 <= '{valid: 1'b1, first: (k_q == '0), last: last_k,
						add_mode: add_q};
					if (last_k) begin
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				ST_WAIT: begin
					ctl_s1 <= '0;
					if (emit) begin
						got_q <= 1'b0;
					end else if (done) begin
						got_q <= 1'b1;
					end
					if (emit) begin
						out_row_q   <= IDX_W'(i_q);
						out_col_q   <= IDX_W'(j_q);
						out_value_q <= acc;
						dim_error_q <= 1'b0;
						last_q      <= last_i && last_j;
						k_q         <= '0;
						if (last_i && last_j) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ISSUE;
							if (last_j) begin
								j_q <= '0;
								i_q <= i_q + IW'(1);
							end else begin
								j_q <= j_q + IW'(1);
							end
						end
					end
				end
				default: begin
					ctl_s1  <= '0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign ctl       = ctl_s1;
	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign dim_error = dim_error_q;
	assign last      = last_q;
endmodule

@@ hw/rtl/matrix_add_multiply.sv @@
// top level of the matrix add / multiply engine
// load items are taken only while idle; ready drops from a start to its last result
// each result element reads k operand pairs in turn, k = cols_a for multiply,
// 1 for add, via the one shared multiplier and the single read port of each store
// a dimension error presents its one result once the output register is free
// reset sets the dimension registers to 8 and op_mode to multiply; stores are not cleared
`timescale 1ns / 1ps
module matrix_add_multiply
	import mam_pkg::*;
#(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mam_in_if.sink     in_ch,
	mam_out_if.source  out_ch,
	mam_cfg_if.sink    cfg_ch
);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	logic                 in_xfer;
	logic                 in_range;
	logic                 we_a, we_b;
	logic                 start;
	logic                 idle;
	logic [AW-1:0]        waddr;
	logic [ELEM_BITS-1:0] wdata;
	logic                 re;
	logic [AW-1:0]        raddr_a, raddr_b;
	logic [ELEM_BITS-1:0] rdata_a, rdata_b;
	mac_ctl_t             ctl;
	logic signed [VAL_W-1:0] acc;
	logic                 done;

	assign in_ch.ready  = idle;
	assign cfg_ch.ready = 1'b1;
	assign in_xfer      = in_ch.valid && idle;

	assign in_range = (5'(in_ch.row_index) < 5'(MAX_DIM))
		&& (5'(in_ch.col_index) < 5'(MAX_DIM));
	assign we_a  = in_xfer && in_range && (in_ch.cmd == CMD_LOAD_A);
	assign we_b  = in_xfer && in_range && (in_ch.cmd == CMD_LOAD_B);
	assign start = in_xfer && (in_ch.cmd == CMD_START);
	assign waddr = AW'(AW'(in_ch.row_index) * AW'(MAX_DIM) + AW'(in_ch.col_index));
	assign wdata = ELEM_BITS'(in_ch.element);

	mam_store #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	mam_store #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	mam_mac #(.ELEM_BITS(ELEM_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a_raw  (rdata_a),
		.b_raw  (rdata_b),
		.acc    (acc),
		.done   (done)
	);

	mam_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_ch.valid),
		.cfg_index (cfg_ch.index),
		.cfg_data  (cfg_ch.data),
		.start     (start),
		.idle      (idle),
		.re        (re),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.ctl       (ctl),
		.acc       (acc),
		.done      (done),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_row   (out_ch.out_row),
		.out_col   (out_ch.out_col),
		.out_value (out_ch.out_value),
		.dim_error (out_ch.dim_error),
		.last      (out_ch.last)
	);
endmodule

@@ hw/rtl/mam_checker.sv @@
// port-level assertions for the matrix add / multiply engine, bound to the top level
`timescale 1ns / 1ps
module mam_checker
	import mam_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [CMD_W-1:0]        in_cmd,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [IDX_W-1:0]        out_row,
	input logic [IDX_W-1:0]        out_col,
	input logic signed [VAL_W-1:0] out_value,
	input logic                    out_dim_error,
	input logic                    out_last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_dim_error |-> out_last && out_value == '0
			&& out_row == '0 && out_col == '0)
		else $error("malformed dimension error result");

	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input ready in the middle of a result sequence");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CMD_START |=> !in_ready)
		else $error("input ready right after a start transfer");
endmodule

bind matrix_add_multiply mam_checker u_mam_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_cmd        (in_ch.cmd),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_row       (out_ch.out_row),
	.out_col       (out_ch.out_col),
	.out_value     (out_ch.out_value),
	.out_dim_error (out_ch.dim_error),
	.out_last      (out_ch.last)
);
